// ===== src/compare_branch_execute_unit_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef COMPARE_BRANCH_EXECUTE_UNIT_ASSERT_SVH
`define COMPARE_BRANCH_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBEU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBEU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbeu_pkg.sv =====
`default_nettype none

package cbeu_pkg;

  localparam int NUM_REGS = 32;
  localparam int PC_INDEX = 31;

  localparam int IDX_W  = 6;
  localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DATA_W = 32;
  localparam int MSZ_W  = 33;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;

  localparam logic [IDX_W:0]     NUM_REGS_C = (IDX_W + 1)'(NUM_REGS);
  localparam logic [IDX_W-1:0]   PC_IDX_C   = IDX_W'(PC_INDEX);
  localparam logic [REG_AW-1:0]  PC_ADDR    = REG_AW'(PC_INDEX);
  localparam logic [MSZ_W-1:0]   MSZ_RESET  = MSZ_W'(65536);

  // config register index, taken from paddr[CFG_AW-1:3]
  localparam logic [CFG_AW-4:0]  CFG_MEM_SIZE = '0;

  localparam logic [2:0] CMD_CMP    = 3'd0;
  localparam logic [2:0] CMD_BRANCH = 3'd1;
  localparam logic [2:0] CMD_NOP    = 3'd2;
  localparam logic [2:0] CMD_WRITE  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [1:0] FMT_8   = 2'd0;
  localparam logic [1:0] FMT_16  = 2'd1;
  localparam logic [1:0] FMT_32  = 2'd2;
  localparam logic [1:0] FMT_BAD = 2'd3;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_WRONG_REG = 3'd1;
  localparam logic [2:0] ST_WRONG_FMT = 3'd2;
  localparam logic [2:0] ST_OOB       = 3'd3;
  localparam logic [2:0] ST_STOP      = 3'd4;

  localparam logic [DATA_W-1:0] FLAG_FIELD = 32'h0000_000f;
  localparam logic [DATA_W-1:0] FLAG_EQUAL = 32'h0000_0004;
  localparam logic [DATA_W-1:0] FLAG_LESS  = 32'h0000_0002;
  localparam logic [DATA_W-1:0] FLAG_MORE  = 32'h0000_0001;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [IDX_W-1:0]  reg_i;
    logic [IDX_W-1:0]  reg_j;
    logic [1:0]        width_format;
    logic [DATA_W-1:0] write_data;
  } instr_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] read_data;
  } result_t;

  // decode outcome for one instruction
  typedef struct packed {
    logic       fin;      // result known at accept
    logic [2:0] status;
    logic       wr_en;    // write command, reg_j valid
    logic       rd_mem;   // needs register file reads
  } dec_t;

  function automatic logic [DATA_W-1:0] fmt_mask(input logic [1:0] fmt);
    logic [DATA_W-1:0] m;
    case (fmt)
      FMT_8:   m = 32'h0000_00ff;
      FMT_16:  m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/cbeu_ram.sv =====
`default_nettype none

module cbeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/cbeu_decode.sv =====
`default_nettype none

module cbeu_decode (
  input  wire cbeu_pkg::instr_t instr,
  output cbeu_pkg::dec_t        dec
);

  logic i_ok;
  logic j_ok;

  assign i_ok = {1'b0, instr.reg_i} < cbeu_pkg::NUM_REGS_C;
  assign j_ok = {1'b0, instr.reg_j} < cbeu_pkg::NUM_REGS_C;

  always_comb begin
    dec = '{fin: 1'b1, status: cbeu_pkg::ST_NONE, wr_en: 1'b0, rd_mem: 1'b0};
    unique case (instr.cmd)
      cbeu_pkg::CMD_CMP: begin
        if (!i_ok || !j_ok || instr.reg_j == cbeu_pkg::PC_IDX_C) begin
          dec.status = cbeu_pkg::ST_WRONG_REG;
        end else if (instr.width_format == cbeu_pkg::FMT_BAD) begin
          dec.status = cbeu_pkg::ST_WRONG_FMT;
        end else begin
          dec.fin    = 1'b0;
          dec.rd_mem = 1'b1;
        end
      end
      cbeu_pkg::CMD_BRANCH: begin
        if (instr.width_format != cbeu_pkg::FMT_32) begin
          dec.status = cbeu_pkg::ST_WRONG_FMT;
        end else if (!i_ok || !j_ok || instr.reg_i == cbeu_pkg::PC_IDX_C) begin
          dec.status = cbeu_pkg::ST_WRONG_REG;
        end else begin
          dec.fin    = 1'b0;
          dec.rd_mem = 1'b1;
        end
      end
      cbeu_pkg::CMD_NOP: begin
        case (instr.width_format)
          cbeu_pkg::FMT_8:  dec.status = cbeu_pkg::ST_STOP;
          cbeu_pkg::FMT_16: dec.status = cbeu_pkg::ST_NONE;
          default:          dec.status = cbeu_pkg::ST_WRONG_FMT;
        endcase
      end
      cbeu_pkg::CMD_WRITE: begin
        if (!j_ok) begin
          dec.status = cbeu_pkg::ST_WRONG_REG;
        end else begin
          dec.wr_en = 1'b1;
        end
      end
      cbeu_pkg::CMD_READ: begin
        if (!j_ok) begin
          dec.status = cbeu_pkg::ST_WRONG_REG;
        end else begin
          dec.fin    = 1'b0;
          dec.rd_mem = 1'b1;
        end
      end
      default: begin
        dec.status = cbeu_pkg::ST_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/compare_branch_execute_unit.sv =====
// Compare / branch execute unit.
// Instruction channel: drive instr and raise start; the transfer happens at a
// clock edge where start is high and busy is low. One result comes back per
// instruction on result, marked by a one-cycle done strobe; the receiver
// cannot stall, so the result must be taken in that cycle.
// Step that ends each instruction (done is registered, high in the cycle after it):
//   nop, write, unknown command and any rejected instruction: the accept,
//   read: S_RD1, compare and untaken or out-of-bounds branch: S_RD2, taken: S_WPC.
// The register file sits in a single RAM with one read and one write port and
// a registered read; every operand takes its own read, and a taken branch
// needs two writes (link, then PC). Instructions that finish at
// accept keep busy low, so they can go back to back.
// Config: APB port, one 33-bit register mem_words at offset 0 (64-bit data).
// Reset (synchronous, rst high) clears all registers to zero through per-entry
// valid bits and sets mem_words to 65536; no clearing pass is needed.
`default_nettype none

module compare_branch_execute_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire cbeu_pkg::instr_t                    instr,
  output logic                                     done,
  output cbeu_pkg::result_t                        result,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cbeu_pkg::CFG_AW-1:0]         paddr,
  input  wire logic [cbeu_pkg::CFG_DW-1:0]         pwdata,
  output logic      [cbeu_pkg::CFG_DW-1:0]         prdata,
  output logic                                     pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_RD3  = 3'd3;
  localparam logic [2:0] S_WPC  = 3'd4;

  logic [2:0]                    state, state_next;
  logic                          done_next;
  cbeu_pkg::result_t             res_next;
  logic [cbeu_pkg::DATA_W-1:0]   a_q, a_next;
  logic [cbeu_pkg::DATA_W-1:0]   b_q, b_next;
  logic [2:0]                    cmd_q;
  logic [1:0]                    fmt_q;
  logic [cbeu_pkg::REG_AW-1:0]   i_q, j_q;
  logic [cbeu_pkg::REG_AW-1:0]   raddr_q;
  logic [cbeu_pkg::NUM_REGS-1:0] valid;
  logic [cbeu_pkg::MSZ_W-1:0]    mem_words;

  logic                          accept;
  cbeu_pkg::dec_t                dec;
  logic                          ram_we;
  logic [cbeu_pkg::REG_AW-1:0]   ram_waddr, ram_raddr;
  logic [cbeu_pkg::DATA_W-1:0]   ram_wdata, ram_rdata, rdv;
  logic [cbeu_pkg::DATA_W-1:0]   mask, am, bm, cmp_flag, cmp_word;
  logic                          cfg_wr;

  cbeu_decode u_decode (
    .instr (instr),
    .dec   (dec)
  );

  cbeu_ram #(
    .WIDTH (cbeu_pkg::DATA_W),
    .DEPTH (cbeu_pkg::NUM_REGS)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // never-written entries read as zero
  assign rdv = valid[raddr_q] ? ram_rdata : '0;

  // compare: rdv holds reg_j, a_q holds reg_i
  assign mask     = cbeu_pkg::fmt_mask(fmt_q);
  assign am       = a_q & mask;
  assign bm       = rdv & mask;
  assign cmp_flag = (bm == am) ? cbeu_pkg::FLAG_EQUAL :
                    (bm > am)  ? cbeu_pkg::FLAG_LESS  : cbeu_pkg::FLAG_MORE;
  assign cmp_word = (rdv & ~cbeu_pkg::FLAG_FIELD) | cmp_flag;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    res_next   = '{status: cbeu_pkg::ST_NONE, read_data: '0};
    a_next     = a_q;
    b_next     = b_q;
    ram_we     = 1'b0;
    ram_waddr  = j_q;
    ram_wdata  = cmp_word;
    ram_raddr  = j_q;
    unique case (state)
      S_IDLE: begin
        ram_raddr = (instr.cmd == cbeu_pkg::CMD_READ) ?
                    instr.reg_j[cbeu_pkg::REG_AW-1:0] :
                    instr.reg_i[cbeu_pkg::REG_AW-1:0];
        if (accept) begin
          if (dec.fin) begin
            done_next       = 1'b1;
            res_next.status = dec.status;
          end
          if (dec.wr_en) begin
            ram_we    = 1'b1;
            ram_waddr = instr.reg_j[cbeu_pkg::REG_AW-1:0];
            ram_wdata = instr.write_data;
          end
          if (dec.rd_mem) begin
            state_next = S_RD1;
          end
        end
      end
      S_RD1: begin
        if (cmd_q == cbeu_pkg::CMD_READ) begin
          done_next          = 1'b1;
          res_next.read_data = rdv;
          state_next         = S_IDLE;
        end else begin
          a_next     = rdv;
          ram_raddr  = j_q;
          state_next = S_RD2;
        end
      end
      S_RD2: begin
        if (cmd_q == cbeu_pkg::CMD_CMP) begin
          ram_we     = 1'b1;
          ram_waddr  = j_q;
          ram_wdata  = cmp_word;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (a_q == '0) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if ({1'b0, rdv} >= mem_words) begin
          done_next       = 1'b1;
          res_next.status = cbeu_pkg::ST_OOB;
          state_next      = S_IDLE;
        end else begin
          b_next     = rdv;
          ram_raddr  = cbeu_pkg::PC_ADDR;
          state_next = S_RD3;
        end
      end
      S_RD3: begin
        // save PC into reg_i; a target equal to reg_i now sees the saved PC
        ram_we     = 1'b1;
        ram_waddr  = i_q;
        ram_wdata  = rdv;
        if (j_q == i_q) begin
          b_next = rdv;
        end
        state_next = S_WPC;
      end
      S_WPC: begin
        ram_we     = 1'b1;
        ram_waddr  = cbeu_pkg::PC_ADDR;
        ram_wdata  = b_q;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[cbeu_pkg::CFG_AW-1:3] == cbeu_pkg::CFG_MEM_SIZE) ?
                  cbeu_pkg::CFG_DW'(mem_words) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      valid     <= '0;
      mem_words <= cbeu_pkg::MSZ_RESET;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (cfg_wr && paddr[cbeu_pkg::CFG_AW-1:3] == cbeu_pkg::CFG_MEM_SIZE) begin
        mem_words <= pwdata[cbeu_pkg::MSZ_W-1:0];
      end
    end
    result  <= res_next;
    a_q     <= a_next;
    b_q     <= b_next;
    raddr_q <= ram_raddr;
    if (accept) begin
      cmd_q <= instr.cmd;
      fmt_q <= instr.width_format;
      i_q   <= instr.reg_i[cbeu_pkg::REG_AW-1:0];
      j_q   <= instr.reg_j[cbeu_pkg::REG_AW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/cbeu_checker.sv =====
`default_nettype none
`include "compare_branch_execute_unit_assert.svh"

module cbeu_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire cbeu_pkg::result_t result
);

  // busy only follows a transfer
  `CBEU_ASSERT_IMP(a_busy_from_accept, clk, rst, $rose(busy), $past(start && !busy), "busy rose without a transfer")

  // a result needs a transfer or work in flight in the cycle before
  `CBEU_ASSERT_IMP(a_done_has_cause, clk, rst, done, $past(busy) || $past(start && !busy), "result with no instruction")

  // only a successful read carries data
  `CBEU_ASSERT_IMP(a_err_no_data, clk, rst, done && result.status != cbeu_pkg::ST_NONE, result.read_data == '0, "error result carries data")

  // longest instruction, a taken branch, keeps busy through S_RD1, S_RD2, S_RD3 and S_WPC
  `CBEU_ASSERT_NXT(a_busy_bounded, clk, rst, busy && $past(busy) && $past(busy, 2) && $past(busy, 3), !busy, "busy held too long")

endmodule

bind compare_branch_execute_unit cbeu_checker u_cbeu_checker (.*);

`default_nettype wire

// ===== dv/compare_branch_execute_unit_test.sv =====
`timescale 1ns / 1ps

module compare_branch_execute_unit_test;
  import cbeu_pkg::*;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int SETTLE_CYCLES = 6;   // longest latency is a taken branch
  localparam int DRAIN_LIMIT = 1000;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam logic [CFG_AW-1:0] MSIZE_ADDR = {CFG_MEM_SIZE, 3'b000};

  typedef struct {
    instr_t  ins;
    bit      typed;
    result_t want;
  } vector_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  instr_t            instr;
  logic              done;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  logic [DATA_W-1:0] shadow_regs [NUM_REGS];
  logic [MSZ_W-1:0]  shadow_msize;
  logic [DATA_W-1:0] written_vals [$];
  result_t           pending_results [$];
  int                mismatches = 0;
  int                idle_pct = 0;

  compare_branch_execute_unit uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .instr   (instr),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("compare_branch_execute_unit verification failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [DATA_W-1:0] reg_value(input logic [IDX_W-1:0] idx);
    return (idx < NUM_REGS) ? shadow_regs[idx] : '0;
  endfunction

  // Applies one instruction to the shadow register file, returns its result.
  function automatic result_t execute_instr(input instr_t x);
    result_t           r;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] v;
    r = '0;
    r.status = ST_NONE;
    case (x.cmd)
      CMD_CMP: begin
        if (x.reg_i >= NUM_REGS || x.reg_j >= NUM_REGS || x.reg_j == PC_IDX_C) begin
          r.status = ST_WRONG_REG;
        end else if (x.width_format == FMT_BAD) begin
          r.status = ST_WRONG_FMT;
        end else begin
          case (x.width_format)
            FMT_8:   mask = 32'h0000_00ff;
            FMT_16:  mask = 32'h0000_ffff;
            default: mask = 32'hffff_ffff;
          endcase
          a = reg_value(x.reg_i) & mask;
          b = reg_value(x.reg_j) & mask;
          v = reg_value(x.reg_j) & ~FLAG_FIELD;
          if (b == a) v |= FLAG_EQUAL;
          else if (b > a) v |= FLAG_LESS;
          else v |= FLAG_MORE;
          shadow_regs[x.reg_j] = v;
        end
      end
      CMD_BRANCH: begin
        if (x.width_format != FMT_32) begin
          r.status = ST_WRONG_FMT;
        end else if (x.reg_i == PC_IDX_C || x.reg_i >= NUM_REGS || x.reg_j >= NUM_REGS) begin
          r.status = ST_WRONG_REG;
        end else if (reg_value(x.reg_i) != '0) begin
          if ({1'b0, reg_value(x.reg_j)} >= shadow_msize) begin
            r.status = ST_OOB;
          end else begin
            // link first, then jump: target is read after the link write
            shadow_regs[x.reg_i] = reg_value(PC_IDX_C);
            if (PC_INDEX < NUM_REGS) shadow_regs[PC_INDEX] = reg_value(x.reg_j);
          end
        end
      end
      CMD_NOP: begin
        if (x.width_format == FMT_8) r.status = ST_STOP;
        else if (x.width_format != FMT_16) r.status = ST_WRONG_FMT;
      end
      CMD_WRITE: begin
        if (x.reg_j >= NUM_REGS) r.status = ST_WRONG_REG;
        else shadow_regs[x.reg_j] = x.write_data;
      end
      CMD_READ: begin
        if (x.reg_j >= NUM_REGS) r.status = ST_WRONG_REG;
        else r.read_data = shadow_regs[x.reg_j];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic vector_t vec(input logic [2:0] c, input int i, input int j,
                                  input logic [1:0] f, input logic [DATA_W-1:0] d,
                                  input bit typed, input logic [2:0] st,
                                  input logic [DATA_W-1:0] rdata);
    vector_t row;
    row.ins.cmd = c;
    row.ins.reg_i = IDX_W'(i);
    row.ins.reg_j = IDX_W'(j);
    row.ins.width_format = f;
    row.ins.write_data = d;
    row.typed = typed;
    row.want.status = st;
    row.want.read_data = rdata;
    return row;
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    int pick;
    pick = $urandom_range(99);
    if (pick < 88) return IDX_W'($urandom_range(NUM_REGS - 1));
    if (pick < 92) return PC_IDX_C;
    return IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1));
  endfunction

  function automatic instr_t random_instr();
    instr_t            x;
    int                pick;
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 22) x.cmd = CMD_WRITE;
    else if (pick < 40) x.cmd = CMD_READ;
    else if (pick < 65) x.cmd = CMD_CMP;
    else if (pick < 88) x.cmd = CMD_BRANCH;
    else if (pick < 95) x.cmd = CMD_NOP;
    else x.cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    x.reg_i = random_index();
    x.reg_j = ($urandom_range(9) == 0) ? x.reg_i : random_index();
    if (x.cmd == CMD_BRANCH && $urandom_range(99) < 85) x.width_format = FMT_32;
    else x.width_format = 2'($urandom_range(3));
    // small values make taken branches likely; reused values hit equal compares
    pick = $urandom_range(99);
    w = (written_vals.size() != 0) ?
        written_vals[$urandom_range(written_vals.size() - 1)] : '0;
    if (pick < 30) v = DATA_W'($urandom_range(0, 'h1ffff));
    else if (pick < 55) v = $urandom;
    else if (pick < 62) v = '0;
    else if (pick < 69) v = '1;
    else if (pick < 82) v = w;
    else if (pick < 91) v = {16'($urandom), w[15:0]};
    else v = {24'($urandom), w[7:0]};
    x.write_data = v;
    if (x.cmd == CMD_WRITE) begin
      written_vals.push_back(v);
      if (written_vals.size() > 16) void'(written_vals.pop_front());
    end
    return x;
  endfunction

  // Holds start until the transfer, then records the expected result.
  task automatic send_instr(input instr_t x, input bit typed, input result_t want);
    result_t predicted;
    start <= 1'b1;
    instr <= x;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = execute_instr(x);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int n;
    start <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mem_words(input logic [MSZ_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MSIZE_ADDR;
    pwdata <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    shadow_msize = value;
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CFG_DW'(shadow_msize))
      flag_mismatch("mem_words readback", prdata, CFG_DW'(shadow_msize));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 64'(result), '0);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          flag_mismatch("status", 64'(result.status), 64'(want.status));
        if (result.read_data !== want.read_data)
          flag_mismatch("read_data", 64'(result.read_data), 64'(want.read_data));
      end
    end
  end

  initial begin : stimulus
    vector_t          directed [$];
    logic [MSZ_W-1:0] phase_msize [PHASES];
    int               phase_idle [PHASES];
    int               ph;
    int               k;
    rst <= 1'b1;
    start <= 1'b0;
    instr <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (k = 0; k < NUM_REGS; k++) shadow_regs[k] = '0;
    shadow_msize = MSZ_RESET;

    phase_msize = '{MSZ_RESET, '0, 33'h1_0000_0000, '1,
                    MSZ_W'($urandom_range(1, 'h20000)), MSZ_W'(1)};
    phase_idle = '{0, 60, 0, 27, 60, 27};

    // cleared file after reset
    directed.push_back(vec(CMD_READ, 0, 0, FMT_8, '0, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_READ, 0, PC_INDEX, FMT_32, '0, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_READ, 0, 63, FMT_8, '0, TYPED, ST_WRONG_REG, '0));
    directed.push_back(vec(CMD_WRITE, 0, 63, FMT_8, '1, TYPED, ST_WRONG_REG, '0));
    // compare rejects: PC as destination, index out of range, bad format
    directed.push_back(vec(CMD_CMP, 0, PC_INDEX, FMT_32, '0, TYPED, ST_WRONG_REG, '0));
    directed.push_back(vec(CMD_CMP, 40, 1, FMT_8, '0, TYPED, ST_WRONG_REG, '0));
    directed.push_back(vec(CMD_CMP, 1, 2, FMT_BAD, '0, TYPED, ST_WRONG_FMT, '0));
    // branch rejects: format checked before registers
    directed.push_back(vec(CMD_BRANCH, PC_INDEX, 63, FMT_16, '0, TYPED, ST_WRONG_FMT, '0));
    directed.push_back(vec(CMD_BRANCH, PC_INDEX, 2, FMT_32, '0, TYPED, ST_WRONG_REG, '0));
    directed.push_back(vec(CMD_BRANCH, 1, 63, FMT_32, '0, TYPED, ST_WRONG_REG, '0));
    directed.push_back(vec(CMD_NOP, 0, 0, FMT_8, '0, TYPED, ST_STOP, '0));
    directed.push_back(vec(CMD_NOP, 0, 0, FMT_16, '0, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_NOP, 0, 0, FMT_32, '0, TYPED, ST_WRONG_FMT, '0));
    directed.push_back(vec(CMD_NOP, 0, 0, FMT_BAD, '0, TYPED, ST_WRONG_FMT, '0));
    directed.push_back(vec(CMD_RSVD_LO, 63, 63, FMT_BAD, '1, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_RSVD_HI, 0, 0, FMT_8, '0, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_WRITE, 0, 1, FMT_8, '1, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_WRITE, 0, 2, FMT_8, 32'h0000_0100, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_CMP, 1, 2, FMT_8, '0, PREDICTED, ST_NONE, '0));
    directed.push_back(vec(CMD_CMP, 2, 1, FMT_32, '0, PREDICTED, ST_NONE, '0));
    directed.push_back(vec(CMD_CMP, 1, 1, FMT_16, '0, PREDICTED, ST_NONE, '0));
    directed.push_back(vec(CMD_READ, 0, 2, FMT_8, '0, PREDICTED, ST_NONE, '0));
    // zero link register: not taken; huge target: out of bounds; then a taken one
    directed.push_back(vec(CMD_BRANCH, 0, 1, FMT_32, '0, PREDICTED, ST_NONE, '0));
    directed.push_back(vec(CMD_BRANCH, 1, 1, FMT_32, '0, PREDICTED, ST_NONE, '0));
    directed.push_back(vec(CMD_WRITE, 0, 3, FMT_8, 32'h0000_fffe, TYPED, ST_NONE, '0));
    directed.push_back(vec(CMD_BRANCH, 2, 3, FMT_32, '0, PREDICTED, ST_NONE, '0));
    directed.push_back(vec(CMD_READ, 0, PC_INDEX, FMT_8, '0, PREDICTED, ST_NONE, '0));
    directed.push_back(vec(CMD_READ, 0, 2, FMT_8, '0, PREDICTED, ST_NONE, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_instr(directed[k].ins, directed[k].typed, directed[k].want);
    drain();

    // receiver cannot stall, so phases vary the sender's idling and mem_words
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) set_mem_words(phase_msize[ph]);
      idle_pct = phase_idle[ph];
      repeat (ITEMS_PER_PHASE) begin
        send_instr(random_instr(), PREDICTED, '0);
        sender_gap();
      end
      drain();
    end

    if (pending_results.size() != 0)
      flag_mismatch("results never returned", 64'(pending_results.size()), 64'(0));
    if (mismatches == 0) begin
      $display("compare_branch_execute_unit verification clean");
    end else begin
      $display("compare_branch_execute_unit verification failed");
    end
    $finish;
  end

endmodule
